// ===== rtl/core/rtfp_pkg.sv =====
package rtfp_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned WORD_W      = 16;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned OUT_DATA_W  = 88;

	localparam logic [POS_W-1:0] POS_SYNC0    = 4'd0;
	localparam logic [POS_W-1:0] POS_SYNC1    = 4'd1;
	localparam logic [POS_W-1:0] POS_DIST_LO  = 4'd6;
	localparam logic [POS_W-1:0] POS_DIST_HI  = 4'd7;
	localparam logic [POS_W-1:0] POS_AZI_LO   = 4'd8;
	localparam logic [POS_W-1:0] POS_AZI_HI   = 4'd9;
	localparam logic [POS_W-1:0] POS_ELEV_LO  = 4'd10;
	localparam logic [POS_W-1:0] POS_ELEV_HI  = 4'd11;
	localparam logic [POS_W-1:0] POS_CHECK    = 4'd12;
	localparam logic [POS_W-1:0] POS_LAST     = 4'd13;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

	typedef struct packed {
		logic [COUNT_W-1:0] good_frames;
		logic               target_present;
		logic [WORD_W-1:0]  elevation_cdeg;
		logic [WORD_W-1:0]  azimuth_cdeg;
		logic [WORD_W-1:0]  distance_cm;
	} result_t;

endpackage

// ===== rtl/core/radar_target_frame_parser.sv =====
// Radar target frame parser.
// The input stream (s_tvalid, s_tready, s_tdata) carries one received serial
// byte per request. The block hunts for the two sync bytes held in its
// configuration registers, collects a 14-byte frame and checks the 8-bit sum
// of bytes 0 to 11 against byte 12. The output stream carries one request per
// completed frame: m_tuser is 0 for a good frame and 1 for a checksum error,
// in which case all of m_tdata is zero.
// The block takes one byte in every cycle unless a stall holds s_tready low.
// Each byte passes through an input register and the position counter and running
// sum; the output register takes a result as its last byte is processed.
// When the receiver stalls, the output register holds its result and bytes
// keep flowing until a second result is ready, which waits in the input
// register and holds s_tready low until the output register frees up.
// Reset clears the valid flags, the position (back to hunting the first sync
// byte), the good-frame count and restores the sync values to 0xAA and 0x55.
// Configuration writes take effect at the next byte and are meant for idle
// periods only.
module radar_target_frame_parser
	import rtfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] rx_byte
	input  logic [BYTE_W-1:0]     s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [15:0] distance_cm, [31:16] azimuth_cdeg, [47:32] elevation_cdeg,
	// [48] target_present, [80:49] good_frames, [87:81] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [0] status
	output logic                  m_tuser
);

	logic [BYTE_W-1:0]  sync_first_q;
	logic [BYTE_W-1:0]  sync_second_q;
	logic               in_valid_s1;
	logic [BYTE_W-1:0]  in_byte_s1;
	logic [POS_W-1:0]   pos_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [BYTE_W-1:0]  check_q;
	logic [WORD_W-1:0]  dist_q;
	logic [WORD_W-1:0]  azi_q;
	logic [WORD_W-1:0]  elev_q;
	logic [COUNT_W-1:0] good_q;
	logic               out_valid_q;
	logic               out_user_q;
	result_t            out_res_q;

	logic               s1_adv;
	logic               proc;
	logic               out_load;
	logic               frame_good;
	logic [POS_W-1:0]   pos_d;
	logic [BYTE_W-1:0]  sum_d;
	logic [COUNT_W-1:0] good_inc;
	result_t            res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s1_adv   = (pos_q != POS_LAST) || !out_valid_q || m_tready;
	assign s_tready = !in_valid_s1 || s1_adv;
	assign proc     = in_valid_s1 && s1_adv;
	assign out_load = proc && (pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
	end

	always_comb begin
		pos_d = pos_q;
		sum_d = sum_q + in_byte_s1;
		case (pos_q)
			POS_SYNC0: begin
				sum_d = in_byte_s1;
				pos_d = (in_byte_s1 == sync_first_q) ? POS_SYNC1 : POS_SYNC0;
			end
			POS_SYNC1: begin
				pos_d = (in_byte_s1 == sync_second_q) ? pos_q + 1'b1 : POS_SYNC0;
			end
			POS_CHECK: begin
				sum_d = sum_q;
				pos_d = POS_LAST;
			end
			POS_LAST: begin
				sum_d = sum_q;
				pos_d = POS_SYNC0;
			end
			default: begin
				pos_d = (pos_q > POS_LAST) ? POS_SYNC0 : pos_q + 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_SYNC0;
		end else if (proc) begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			sum_q <= sum_d;
			case (pos_q)
				POS_DIST_LO: dist_q[BYTE_W-1:0]       <= in_byte_s1;
				POS_DIST_HI: dist_q[WORD_W-1:BYTE_W]  <= in_byte_s1;
				POS_AZI_LO:  azi_q[BYTE_W-1:0]        <= in_byte_s1;
				POS_AZI_HI:  azi_q[WORD_W-1:BYTE_W]   <= in_byte_s1;
				POS_ELEV_LO: elev_q[BYTE_W-1:0]       <= in_byte_s1;
				POS_ELEV_HI: elev_q[WORD_W-1:BYTE_W]  <= in_byte_s1;
				POS_CHECK:   check_q                  <= in_byte_s1;
				default: ;
			endcase
		end
	end

	assign frame_good = (sum_q == check_q);
	assign good_inc   = good_q + 1'b1;

	always_comb begin
		res_d = '0;
		if (frame_good) begin
			res_d.distance_cm    = dist_q;
			res_d.azimuth_cdeg   = azi_q;
			res_d.elevation_cdeg = elev_q;
			res_d.target_present = (dist_q != '0);
			res_d.good_frames    = good_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load && frame_good) begin
				good_q <= good_inc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q  <= res_d;
			out_user_q <= !frame_good;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res_q};

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("frame position out of range");

	a_good_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && frame_good) |=> (good_q == $past(good_inc)))
		else $error("good-frame count did not advance by one");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error result carries nonzero data");

	a_target_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |->
		(out_res_q.target_present == (out_res_q.distance_cm != '0)))
		else $error("target flag disagrees with distance");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !s1_adv) |-> (pos_q == POS_LAST && m_tvalid && !m_tready))
		else $error("input stage stalled without a blocked result");
`endif

endmodule

// ===== tb/sv/tb_radar_target_frame_parser.sv =====
module tb_radar_target_frame_parser;
	import rtfp_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int FRAME_BYTES   = 14;
	localparam int DIRECTED_ROWS = 31;
	localparam int PHASES        = 6;

	typedef struct packed {
		logic    status;
		result_t fields;
	} frame_report_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              typed_in;
		frame_report_t     report;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [BYTE_W-1:0]     cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	logic [BYTE_W-1:0]  exp_sync_first = SYNC_FIRST_RST;
	logic [BYTE_W-1:0]  exp_sync_second = SYNC_SECOND_RST;
	logic [POS_W-1:0]   frame_pos = POS_SYNC0;
	logic [BYTE_W-1:0]  frame_bytes [FRAME_BYTES];
	logic [COUNT_W-1:0] good_count = '0;

	frame_report_t pending_reports [$];
	int            reports_predicted = 0;
	int            errors = 0;
	int            cycle_count = 0;
	logic          tx_steady = 1'b0;
	logic          rx_steady = 1'b0;

	// A noise byte, a second sync byte equal to the first one, then a good frame
	// at the field extremes and a frame with a bad checksum.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h00, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0},
		'{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0},
		'{8'hFB, 1'b0, '0},
		'{8'h00, 1'b1, '{1'b0, '{32'd1, 1'b1, 16'h7FFF, 16'h8000, 16'hFFFF}}},
		'{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h11, 1'b0, '0}, '{8'h22, 1'b0, '0},
		'{8'h33, 1'b0, '0}, '{8'h44, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b1, '{1'b1, '0}}
	};

	radar_target_frame_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic parse_rx_byte(input logic [BYTE_W-1:0] value,
			output frame_report_t report);
		logic [BYTE_W-1:0] sum;
		int                i;
		report = '0;
		if (frame_pos == POS_SYNC0 && value != exp_sync_first)
			return 1'b0;
		if (frame_pos == POS_SYNC1 && value != exp_sync_second) begin
			frame_pos = POS_SYNC0;
			return 1'b0;
		end
		frame_bytes[frame_pos] = value;
		if (frame_pos != POS_LAST) begin
			frame_pos = frame_pos + 1'b1;
			return 1'b0;
		end
		frame_pos = POS_SYNC0;
		sum = '0;
		for (i = 0; i <= int'(POS_ELEV_HI); i++)
			sum = sum + frame_bytes[i];
		if (sum != frame_bytes[POS_CHECK]) begin
			report.status = 1'b1;
			return 1'b1;
		end
		good_count = good_count + 1'b1;
		report.fields.distance_cm    = {frame_bytes[POS_DIST_HI], frame_bytes[POS_DIST_LO]};
		report.fields.azimuth_cdeg   = {frame_bytes[POS_AZI_HI], frame_bytes[POS_AZI_LO]};
		report.fields.elevation_cdeg = {frame_bytes[POS_ELEV_HI], frame_bytes[POS_ELEV_LO]};
		report.fields.target_present = (report.fields.distance_cm != '0);
		report.fields.good_frames    = good_count;
		return 1'b1;
	endfunction

	task automatic send_rx_byte(input logic [BYTE_W-1:0] value, input logic typed_in,
			input frame_report_t typed_report);
		int            gap;
		frame_report_t predicted;
		gap = tx_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		if (parse_rx_byte(value, predicted)) begin
			pending_reports.push_back(typed_in ? typed_report : predicted);
			reports_predicted++;
		end
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync(input logic [CFG_IDX_W-1:0] index, input logic [BYTE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		case (index)
			REG_SYNC_FIRST: begin
				exp_sync_first = value;
			end
			REG_SYNC_SECOND: begin
				exp_sync_second = value;
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin : report_check
		frame_report_t exp_report;
		result_t       got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result, tuser %0b tdata %h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				exp_report = pending_reports.pop_front();
				if (m_tuser !== exp_report.status) begin
					$display("%0t: status expected %0b got %0b", $time, exp_report.status,
						m_tuser);
					errors++;
				end
				if (got.distance_cm !== exp_report.fields.distance_cm) begin
					$display("%0t: distance_cm expected %h got %h", $time,
						exp_report.fields.distance_cm, got.distance_cm);
					errors++;
				end
				if (got.azimuth_cdeg !== exp_report.fields.azimuth_cdeg) begin
					$display("%0t: azimuth_cdeg expected %h got %h", $time,
						exp_report.fields.azimuth_cdeg, got.azimuth_cdeg);
					errors++;
				end
				if (got.elevation_cdeg !== exp_report.fields.elevation_cdeg) begin
					$display("%0t: elevation_cdeg expected %h got %h", $time,
						exp_report.fields.elevation_cdeg, got.elevation_cdeg);
					errors++;
				end
				if (got.target_present !== exp_report.fields.target_present) begin
					$display("%0t: target_present expected %0b got %0b", $time,
						exp_report.fields.target_present, got.target_present);
					errors++;
				end
				if (got.good_frames !== exp_report.fields.good_frames) begin
					$display("%0t: good_frames expected %0d got %0d", $time,
						exp_report.fields.good_frames, got.good_frames);
					errors++;
				end
				if (m_tdata[OUT_DATA_W-1:$bits(result_t)] !== '0) begin
					$display("%0t: padding expected 0 got %h", $time,
						m_tdata[OUT_DATA_W-1:$bits(result_t)]);
					errors++;
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : byte_source
		int                row;
		int                phase;
		int                i;
		int                noise;
		int                phase_bytes;
		int                phase_start;
		logic              broken;
		logic [BYTE_W-1:0] first_val;
		logic [BYTE_W-1:0] second_val;
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] frame [FRAME_BYTES];

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++)
			send_rx_byte(directed_rows[row].rx_byte, directed_rows[row].typed_in,
				directed_rows[row].report);
		drain_reports();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					first_val  = 8'h00;
					second_val = 8'hFF;
				end
				1: begin
					first_val  = 8'hFF;
					second_val = 8'h00;
				end
				2: begin
					first_val  = 8'hFF;
					second_val = 8'hFF;
				end
				3: begin
					first_val  = SYNC_FIRST_RST;
					second_val = SYNC_SECOND_RST;
				end
				default: begin
					first_val  = BYTE_W'($urandom);
					second_val = BYTE_W'($urandom);
				end
			endcase
			write_sync(REG_SYNC_FIRST, first_val);
			write_sync(REG_SYNC_SECOND, second_val);
			cfg_we <= 1'b0;

			phase_bytes = 0;
			phase_start = reports_predicted;
			while (phase_bytes < 56 || reports_predicted - phase_start < 4) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				noise = $urandom_range(0, 4);
				if (noise > 2)
					noise = 0;
				repeat (noise) send_rx_byte(BYTE_W'($urandom), 1'b0, '0);

				frame[0] = exp_sync_first;
				frame[1] = exp_sync_second;
				broken = ($urandom_range(0, 7) == 0);
				if (broken) begin
					frame[1] = $urandom_range(0, 1) ? exp_sync_first : BYTE_W'($urandom);
					if (frame[1] == exp_sync_second)
						frame[1] = ~exp_sync_second;
				end
				for (i = 2; i < FRAME_BYTES; i++)
					frame[i] = BYTE_W'($urandom);
				if ($urandom_range(0, 7) == 0) begin
					frame[POS_DIST_LO] = '0;
					frame[POS_DIST_HI] = '0;
				end
				sum = '0;
				for (i = 0; i < int'(POS_CHECK); i++)
					sum = sum + frame[i];
				if ($urandom_range(0, 4) != 0)
					frame[POS_CHECK] = sum;

				for (i = 0; i < (broken ? 2 : FRAME_BYTES); i++)
					send_rx_byte(frame[i], 1'b0, '0);
				phase_bytes += broken ? 2 : FRAME_BYTES;

				// Now and then hold off until the output side has caught up.
				if ($urandom_range(0, 9) == 0)
					drain_reports();
			end
			drain_reports();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rtfp_pkg.sv
rtl/core/radar_target_frame_parser.sv
tb/sv/tb_radar_target_frame_parser.sv
